[sv/bdke_pkg.sv]
// Shared types and constants for the decimal keycode emitter.
// Depends on nothing; the front, back and top-level files import it.
`default_nettype none

package bdke_pkg;

   localparam int COUNT_IN_W = 32;
   localparam int POS_W      = 8;
   localparam int USAGE_W    = 6;

   localparam logic [USAGE_W-1:0] USAGE_ZERO     = 6'h27;
   localparam logic [USAGE_W-1:0] USAGE_ONE_BASE = 6'h1E;

   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

   typedef struct packed {
      logic [COUNT_IN_W-1:0] count_value;
      logic [POS_W-1:0]      key_position;
   } req_type;

   typedef struct packed {
      logic [USAGE_W-1:0] usage_code;
      logic               is_press;
      logic [POS_W-1:0]   out_position;
      logic               last;
   } rsp_type;

   function automatic logic [USAGE_W-1:0] usage_of(input logic [3:0] digit);
      logic [USAGE_W-1:0] code;
      if (digit == 4'd0) begin
         code = USAGE_ZERO;
      end else begin
         code = USAGE_ONE_BASE + USAGE_W'(digit) - USAGE_W'(1);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

[sv/bdke_front.sv]
// Front end: accepts a request and converts its count to BCD, one bit a cycle.
// Depends on bdke_pkg; feeds bdke_queue.
`default_nettype none

module bdke_front
   import bdke_pkg::*;
#(
   parameter  int COUNT_WIDTH = 32,
   parameter  int MAX_DIGITS  = 10,
   localparam int ENTRY_W     = 4 * MAX_DIGITS + POS_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data,
   input  logic               q_full
);

   localparam int BIT_W = $clog2(COUNT_WIDTH);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0]       sh_ff, sh_in;
   logic [MAX_DIGITS-1:0][3:0]   bcd_ff, bcd_in;
   logic                         ovf_ff, ovf_in;
   logic [BIT_W-1:0]             cnt_ff, cnt_in;
   logic [POS_W-1:0]             pos_ff, pos_in;

   logic [MAX_DIGITS-1:0][3:0]   adj;
   logic [4*MAX_DIGITS:0]        shifted;

   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (adj[i] >= BCD_ADJ_LIMIT) begin
            adj[i] = adj[i] + BCD_ADJ_ADD;
         end
      end
      shifted = {adj, sh_ff[COUNT_WIDTH-1]};
   end

   assign req_stall = (state_ff != F_IDLE);
   assign q_push    = (state_ff == F_PUSH) && !q_full;
   assign q_data    = {ovf_ff, pos_ff, bcd_ff};

   always_comb begin
      state_in = state_ff;
      sh_in    = sh_ff;
      bcd_in   = bcd_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               sh_in    = COUNT_WIDTH'(req_payload.count_value);
               pos_in   = req_payload.key_position;
               bcd_in   = '0;
               ovf_in   = 1'b0;
               cnt_in   = '0;
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            bcd_in = shifted[4*MAX_DIGITS-1:0];
            ovf_in = ovf_ff | shifted[4*MAX_DIGITS];
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff + BIT_W'(1);
            if (cnt_ff == BIT_W'(COUNT_WIDTH - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
   end

endmodule

`default_nettype wire

[sv/bdke_queue.sv]
// Two-entry queue between front and back end.
// Depends on nothing but its width parameter.
`default_nettype none

module bdke_queue #(
   parameter int WIDTH = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff;
   logic             do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign valid    = (fill_ff != 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/bdke_back.sv]
// Back end: skips leading zeros (unless the conversion overflowed) and emits press/release keycodes per digit.
// Depends on bdke_pkg; drains bdke_queue, drives the response register.
`default_nettype none

module bdke_back
   import bdke_pkg::*;
#(
   parameter  int MAX_DIGITS = 10,
   localparam int ENTRY_W    = 4 * MAX_DIGITS + POS_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload
);

   localparam int DIG_W = $clog2(MAX_DIGITS);

   typedef enum logic [3:0] {
      B_IDLE    = 4'b0001,
      B_SKIP    = 4'b0010,
      B_PRESS   = 4'b0100,
      B_RELEASE = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [MAX_DIGITS-1:0][3:0] dig_ff, dig_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       skip_ff, skip_in;
   logic [DIG_W-1:0]           idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       out_free;
   logic [3:0]                 cur_digit;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign cur_digit   = dig_ff[idx_ff];
   assign q_pop       = (state_ff == B_IDLE) && q_valid;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               dig_in   = q_data[4*MAX_DIGITS-1:0];
               pos_in   = q_data[4*MAX_DIGITS +: POS_W];
               skip_in  = !q_data[ENTRY_W-1];
               idx_in   = DIG_W'(MAX_DIGITS - 1);
               state_in = B_SKIP;
            end
         end
         B_SKIP: begin
            if (skip_ff && (idx_ff != '0) && (cur_digit == 4'd0)) begin
               idx_in = idx_ff - DIG_W'(1);
            end else begin
               state_in = B_PRESS;
            end
         end
         B_PRESS: begin
            if (out_free) begin
               rsp_in.usage_code   = usage_of(cur_digit);
               rsp_in.is_press     = 1'b1;
               rsp_in.out_position = pos_ff;
               rsp_in.last         = 1'b0;
               rsp_valid_in        = 1'b1;
               state_in            = B_RELEASE;
            end
         end
         B_RELEASE: begin
            if (out_free) begin
               rsp_in.usage_code   = usage_of(cur_digit);
               rsp_in.is_press     = 1'b0;
               rsp_in.out_position = pos_ff;
               rsp_in.last         = (idx_ff == '0);
               rsp_valid_in        = 1'b1;
               if (idx_ff == '0) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff - DIG_W'(1);
                  state_in = B_PRESS;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dig_ff  <= dig_in;
      pos_ff  <= pos_in;
      skip_ff <= skip_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

[sv/binary_to_decimal_keycode_emitter.sv]
// Top level of the decimal keycode emitter: front converter, queue, back emitter.
// Depends on bdke_pkg, bdke_front, bdke_queue, bdke_back.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall req_payload (count_value, key_position)
//   rsp      out  rsp_valid/rsp_stall rsp_payload (usage_code, is_press, ...)
//
// Front: accepts a request, runs one shift-add-3 step per count bit, then pushes
// the result into the two-entry queue, waiting while the queue is full.
// Back: pops an entry, finds the first digit by skipping leading zeros, then emits
// a press and a release per digit, each held while rsp_stall is high.
// A request emits 2 to 2*MAX_DIGITS results.
// Synchronous active-high reset clears the state machines, queue and rsp_valid.
// rsp_stall only holds the back end; the front keeps converting until the queue is full.
`default_nettype none

module binary_to_decimal_keycode_emitter
   import bdke_pkg::*;
#(
   parameter int COUNT_WIDTH = 32,
   parameter int MAX_DIGITS  = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int ENTRY_W = 4 * MAX_DIGITS + POS_W + 1;

   logic               q_push, q_full, q_pop, q_valid;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   bdke_front #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_push      (q_push),
      .q_data      (q_wdata),
      .q_full      (q_full)
   );

   bdke_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   bdke_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
